// ===== rtl/core/mips_subset_execute_unit_assert.svh =====
// Assertion helpers for the execute unit
`ifndef MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// Implication checked on every clock, muted in reset
`define MSE_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("%m: label failed");

// Next-cycle implication, muted in reset
`define MSE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("%m: label failed");

`endif

// ===== rtl/core/mse_pkg.sv =====
package mse_pkg;

  typedef enum logic [5:0] {
    OP_LUI = 6'd0, OP_ADD = 6'd1, OP_ADDI = 6'd2, OP_ADDIU = 6'd3, OP_SUB = 6'd4,
    OP_SUBU = 6'd5, OP_SLT = 6'd6, OP_SLTI = 6'd7, OP_SLTU = 6'd8, OP_SLTIU = 6'd9,
    OP_AND = 6'd10, OP_ANDI = 6'd11, OP_OR = 6'd12, OP_ORI = 6'd13, OP_XOR = 6'd14,
    OP_XORI = 6'd15, OP_NOR = 6'd16, OP_SLL = 6'd17, OP_SLLV = 6'd18, OP_SRL = 6'd19,
    OP_SRLV = 6'd20, OP_SRA = 6'd21, OP_SRAV = 6'd22, OP_BEQ = 6'd23, OP_BNE = 6'd24,
    OP_BGEZAL = 6'd25, OP_J = 6'd26, OP_JAL = 6'd27, OP_JR = 6'd28, OP_JALR = 6'd29,
    OP_MUL = 6'd30, OP_MULT = 6'd31, OP_DIV = 6'd32, OP_DIVU = 6'd33, OP_MFHI = 6'd34,
    OP_MFLO = 6'd35, OP_MTHI = 6'd36, OP_NOP = 6'd37
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_DIVFIX, ST_DONE
  } state_t;

  localparam logic [31:0] JUMP_REGION_MASK = 32'hF800_0000;
  localparam logic [4:0]  LINK_REG         = 5'd31;
  localparam int          DIV_STEPS        = 32;

  typedef struct packed {
    logic [5:0]  operation;
    logic [4:0]  dest_reg;
    logic [4:0]  first_src_reg;
    logic [4:0]  second_src_reg;
    logic [15:0] immediate;
    logic [4:0]  shift_amount;
    logic [26:0] jump_target;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [4:0]  written_reg;
    logic [31:0] written_value;
    logic [31:0] next_pc;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic        divide_by_zero;
  } out_item_t;

endpackage

// ===== rtl/core/mips_subset_execute_unit.sv =====
// Integer execute unit: one decoded instruction per transfer, one result per
// instruction. The register file sits in a RAM with one registered read port.
// Most operations pass through these states in order: ST_IDLE takes the transfer
// (and starts the rs read), ST_READ captures rs, ST_EXEC captures rt, ST_MUL
// executes and ST_DONE presents the result. The result stays presented while
// out_ready is low, and in_ready comes back the cycle after the result transfer.
// mul and mult take an extra ST_MUL step (sign fix on a 32x32 magnitude product).
// div and divu run a restoring divider one quotient bit per cycle: a start step,
// one step per quotient bit and a sign-fix step; a zero divisor skips the divider.
// After reset the register file is cleared, one entry per cycle, and no
// instruction is taken until the clearing pass ends. in_ready is low while an
// item is in work.
module mips_subset_execute_unit #(
  parameter logic [31:0] PC_RESET_VALUE = 32'd4194304,
  parameter logic [31:0] PC_STEP        = 32'd2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mse_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mse_pkg::out_item_t out_data
);

  mse_pkg::state_t state, state_next;
  mse_pkg::in_item_t ins;
  logic [31:0] a, b, hi, lo, pc;
  logic [5:0]  cnt;
  logic        clearing;
  logic [4:0]  clr_addr;
  // divider / multiplier working registers
  logic [31:0] quo, rem, dvs;
  logic        neg_q, neg_r;
  logic [63:0] prod;
  logic        mul_neg;
  mse_pkg::out_item_t res, res_next;

  // register file
  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr;
  logic [31:0] rf_wdata, rf_rdata;

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf (
    .clk, .wr_en(rf_we), .wr_addr(rf_waddr), .wr_data(rf_wdata),
    .rd_addr(rf_raddr), .rd_data(rf_rdata)
  );

  // read address: rs on accept, rt in read cycle
  assign rf_raddr = (state == mse_pkg::ST_IDLE) ? in_data.first_src_reg : ins.second_src_reg;

  // write port: clearing pass or result commit
  always_comb begin
    if (clearing) begin
      rf_we = 1'b1; rf_waddr = clr_addr; rf_wdata = '0;
    end else begin
      rf_we    = (state == mse_pkg::ST_DONE) && out_ready && res.write_enable;
      rf_waddr = res.written_reg;
      rf_wdata = res.written_value;
    end
  end

  assign in_ready  = (state == mse_pkg::ST_IDLE) && !clearing;
  assign out_valid = (state == mse_pkg::ST_DONE);
  assign out_data  = res;

  // execute datapath
  logic [31:0] simm, zimm, seq, brn, alu;
  logic        we, dz, take, wr_rt, wr_link;
  logic [32:0] diff;
  logic [63:0] pm;
  logic [31:0] npc;

  assign simm = {{16{ins.immediate[15]}}, ins.immediate};
  assign zimm = {16'd0, ins.immediate};
  assign seq  = pc + PC_STEP;
  assign brn  = pc + 32'(PC_STEP * simm);
  assign pm   = {32'd0, (a[31] ? 32'(-a) : a)} * {32'd0, (b[31] ? 32'(-b) : b)};
  // trial subtraction for one divider step
  assign diff = {rem, quo[31]} - {1'b0, dvs};

  always_comb begin
    we = 1'b1; wr_rt = 1'b0; wr_link = 1'b0; alu = '0; npc = seq; dz = 1'b0;
    take = 1'b0;
    unique case (ins.operation) inside
      mse_pkg::OP_LUI:  begin wr_rt = 1'b1; alu = {ins.immediate, 16'd0}; end
      mse_pkg::OP_ADD:  alu = a + b;
      mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin wr_rt = 1'b1; alu = a + simm; end
      mse_pkg::OP_SUB, mse_pkg::OP_SUBU: alu = a - b;
      mse_pkg::OP_SLT:  alu = {31'd0, $signed(a) < $signed(b)};
      mse_pkg::OP_SLTI: begin wr_rt = 1'b1; alu = {31'd0, $signed(a) < $signed(simm)}; end
      mse_pkg::OP_SLTU: alu = {31'd0, a < b};
      mse_pkg::OP_SLTIU: begin wr_rt = 1'b1; alu = {31'd0, a < simm}; end
      mse_pkg::OP_AND:  alu = a & b;
      mse_pkg::OP_ANDI: begin wr_rt = 1'b1; alu = a & zimm; end
      mse_pkg::OP_OR:   alu = a | b;
      mse_pkg::OP_ORI:  begin wr_rt = 1'b1; alu = a | zimm; end
      mse_pkg::OP_XOR:  alu = a ^ b;
      mse_pkg::OP_XORI: begin wr_rt = 1'b1; alu = a ^ zimm; end
      mse_pkg::OP_NOR:  alu = ~(a | b);
      mse_pkg::OP_SLL:  alu = a << ins.shift_amount;
      mse_pkg::OP_SLLV: alu = a << b[4:0];
      mse_pkg::OP_SRL:  alu = a >> ins.shift_amount;
      mse_pkg::OP_SRLV: alu = a >> b[4:0];
      mse_pkg::OP_SRA:  alu = 32'($signed(a) >>> ins.shift_amount);
      mse_pkg::OP_SRAV: alu = 32'($signed(a) >>> b[4:0]);
      mse_pkg::OP_BEQ:  begin we = 1'b0; if (a == b) npc = brn; end
      mse_pkg::OP_BNE:  begin we = 1'b0; if (a != b) npc = brn; end
      mse_pkg::OP_BGEZAL: begin
        take = !a[31]; we = take; wr_link = 1'b1; alu = seq;
        if (take) npc = brn;
      end
      mse_pkg::OP_J:    begin we = 1'b0; npc = (pc & mse_pkg::JUMP_REGION_MASK) | 32'(ins.jump_target); end
      mse_pkg::OP_JAL:  begin
        wr_link = 1'b1; alu = seq;
        npc = (pc & mse_pkg::JUMP_REGION_MASK) | 32'(ins.jump_target);
      end
      mse_pkg::OP_JR:   begin we = 1'b0; npc = a; end
      mse_pkg::OP_JALR: begin alu = seq; npc = a; end
      mse_pkg::OP_MFHI: alu = hi;
      mse_pkg::OP_MFLO: alu = lo;
      mse_pkg::OP_MUL:  alu = '0;
      // mult only updates hi and lo
      mse_pkg::OP_MULT: we = 1'b0;
      mse_pkg::OP_DIV, mse_pkg::OP_DIVU: begin we = 1'b0; dz = (b == '0); end
      default: we = 1'b0;
    endcase
  end

  // state register and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mse_pkg::ST_IDLE;
      clearing <= 1'b1;
      clr_addr <= '0;
      hi <= '0; lo <= '0; pc <= PC_RESET_VALUE;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_addr <= clr_addr + 5'd1;
        if (clr_addr == 5'd31) clearing <= 1'b0;
      end
      if (state == mse_pkg::ST_DONE && out_ready) begin
        pc <= res.next_pc; hi <= res.hi_value; lo <= res.lo_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    case (state)
      mse_pkg::ST_IDLE: if (in_valid && in_ready) ins <= in_data;
      mse_pkg::ST_READ: a <= rf_rdata;
      mse_pkg::ST_EXEC: begin
        b <= rf_rdata;
      end
      default: ;
    endcase
    // multiplier: magnitude product registered, sign applied next cycle
    if (state == mse_pkg::ST_MUL && cnt == 6'd0) begin
      prod <= pm; mul_neg <= a[31] ^ b[31];
    end
    // divider start and iteration
    if (state == mse_pkg::ST_DIV) begin
      if (cnt == 6'd0) begin
        neg_q <= (ins.operation == mse_pkg::OP_DIV) && (a[31] ^ b[31]);
        neg_r <= (ins.operation == mse_pkg::OP_DIV) && a[31];
        quo   <= (ins.operation == mse_pkg::OP_DIV && a[31]) ? 32'(-a) : a;
        dvs   <= (ins.operation == mse_pkg::OP_DIV && b[31]) ? 32'(-b) : b;
        rem   <= '0;
      end else begin
        if (!diff[32]) rem <= diff[31:0];
        else           rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], !diff[32]};
      end
    end
  end

  // count of cycles inside a multi-cycle state
  always_ff @(posedge clk) begin
    if (rst || state_next != state) cnt <= '0;
    else cnt <= cnt + 6'd1;
  end

  // sequencer and result assembly
  always_comb begin
    state_next = state;
    res_next   = res;
    unique case (state)
      mse_pkg::ST_IDLE: if (in_valid && in_ready) state_next = mse_pkg::ST_READ;
      mse_pkg::ST_READ: state_next = mse_pkg::ST_EXEC;
      mse_pkg::ST_EXEC: begin
        // b lands this edge; evaluate next cycle via an extra pass
        state_next = mse_pkg::ST_MUL;
      end
      mse_pkg::ST_MUL: begin
        if (cnt == 6'd0) begin
          res_next.write_enable   = we && ((wr_link ? mse_pkg::LINK_REG
                                    : (wr_rt ? ins.second_src_reg : ins.dest_reg)) != 5'd0);
          res_next.written_reg    = wr_link ? mse_pkg::LINK_REG
                                    : (wr_rt ? ins.second_src_reg : ins.dest_reg);
          res_next.written_value  = alu;
          res_next.next_pc        = npc;
          res_next.hi_value       = (ins.operation == mse_pkg::OP_MTHI) ? a : hi;
          res_next.lo_value       = lo;
          res_next.divide_by_zero = dz;
          if (ins.operation == mse_pkg::OP_MUL || ins.operation == mse_pkg::OP_MULT)
            state_next = mse_pkg::ST_MUL;
          else if ((ins.operation == mse_pkg::OP_DIV || ins.operation == mse_pkg::OP_DIVU)
                   && !dz)
            state_next = mse_pkg::ST_DIV;
          else
            state_next = mse_pkg::ST_DONE;
        end else begin
          if (ins.operation == mse_pkg::OP_MUL) begin
            res_next.written_value = mul_neg ? 32'(-prod) : prod[31:0];
          end else begin
            res_next.hi_value = mul_neg ? 32'((-prod) >> 32) : prod[63:32];
            res_next.lo_value = mul_neg ? 32'(-prod) : prod[31:0];
          end
          if (!res.write_enable) res_next.written_value = '0;
          state_next = mse_pkg::ST_DONE;
        end
        if (!res_next.write_enable) begin
          res_next.written_reg = '0; res_next.written_value = '0;
        end
      end
      mse_pkg::ST_DIV: if (cnt == 6'(mse_pkg::DIV_STEPS)) state_next = mse_pkg::ST_DIVFIX;
      mse_pkg::ST_DIVFIX: begin
        res_next.lo_value = neg_q ? 32'(-quo) : quo;
        res_next.hi_value = neg_r ? 32'(-rem) : rem;
        state_next = mse_pkg::ST_DONE;
      end
      mse_pkg::ST_DONE: if (out_ready) state_next = mse_pkg::ST_IDLE;
      default: state_next = mse_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/mse_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== rtl/core/mse_checker.sv =====
`include "mips_subset_execute_unit_assert.svh"
// Port-level checks for the execute unit
module mse_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input mse_pkg::out_item_t out_data,
  input logic               out_valid,
  input logic               out_ready
);
  // one item in work at a time: no intake while a result waits
  `MSE_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  // a result that is held stays the same
  `MSE_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, $stable(out_data))
  // dropped writes show as zero
  `MSE_ASSERT_IMP(a_zero_wr, clk, rst, out_valid && !out_data.write_enable,
                  out_data.written_reg == 5'd0 && out_data.written_value == 32'd0)
  // never ready the cycle after taking an item
  `MSE_ASSERT_NEXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)
endmodule

bind mips_subset_execute_unit mse_checker u_mse_checker (
  .clk, .rst, .in_valid, .in_ready, .out_data, .out_valid, .out_ready
);
